// File: rtl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types and codes for the sift / min-prefix reposition block.
// ----------------------------------------------------------------------------
package smp_pkg;

   localparam int OP_BITS    = 2;
   localparam int INDEX_BITS = 6;
   localparam int ID_BITS    = 16;
   localparam int CPOS_BITS  = 6;
   localparam int DIFF_BITS  = 24;
   localparam int SUM_BITS   = 30;

   typedef logic [OP_BITS-1:0]           op_type;
   typedef logic [INDEX_BITS-1:0]        index_type;
   typedef logic [ID_BITS-1:0]           node_type;
   typedef logic [CPOS_BITS-1:0]         cpos_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;

   localparam op_type OP_LOAD = 2'd0;
   localparam op_type OP_DIFF = 2'd1;
   localparam op_type OP_READ = 2'd2;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_SIFT = 1'b1;

   localparam sum_type SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam sum_type SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   // control from the sequencer to the prefix unit
   typedef struct packed {
      logic step;
      logic clear;
   } prefix_ctl_type;

endpackage

// File: rtl/smp_if.sv
// ----------------------------------------------------------------------------
// smp_req_if / smp_rsp_if
// Valid/ready channels for requests and results of the reposition block.
// ----------------------------------------------------------------------------
interface smp_req_if;
   logic                valid;
   logic                ready;
   smp_pkg::op_type     op;
   smp_pkg::index_type  index;
   smp_pkg::node_type   node_id;
   smp_pkg::cpos_type   current_position;
   smp_pkg::diff_type   crossing_diff;
   logic                last;

   modport source (output valid, output op, output index, output node_id,
                   output current_position, output crossing_diff, output last,
                   input ready);
   modport sink   (input valid, input op, input index, input node_id,
                   input current_position, input crossing_diff, input last,
                   output ready);
endinterface

interface smp_rsp_if;
   logic                valid;
   logic                ready;
   smp_pkg::node_type   read_node;
   smp_pkg::cpos_type   new_position;
   smp_pkg::sum_type    best_prefix;
   logic                kind;

   modport source (output valid, output read_node, output new_position,
                   output best_prefix, output kind, input ready);
   modport sink   (input valid, input read_node, input new_position,
                   input best_prefix, input kind, output ready);
endinterface

// File: rtl/smp_order_ram.sv
// ----------------------------------------------------------------------------
// smp_order_ram
// Layer order table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module smp_order_ram #(
   parameter int DEPTH     = 64,
   parameter int WIDTH     = 16,
   parameter int ADDR_BITS = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/smp_prefix_unit.sv
// ----------------------------------------------------------------------------
// smp_prefix_unit
// Saturating prefix sum of the diffs with running minimum and tie-break on
// distance from the sifted node's position.
// ----------------------------------------------------------------------------
module smp_prefix_unit #(
   parameter int MAX_LAYER = 64,
   parameter int CNT_BITS  = $clog2(MAX_LAYER + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  smp_pkg::prefix_ctl_type       ctl,
   input  smp_pkg::cpos_type             cur_pos,
   input  smp_pkg::diff_type             diff,
   output smp_pkg::sum_type              best_sum,
   output logic [CNT_BITS-1:0]           best_next,
   output logic [CNT_BITS-1:0]           diff_count
);
   import smp_pkg::*;

   localparam int SPAN      = (MAX_LAYER > 64) ? MAX_LAYER : 64;
   localparam int DIST_BITS = $clog2(SPAN);
   localparam int CMP_BITS  = ((CNT_BITS > CPOS_BITS) ? CNT_BITS : CPOS_BITS) + 1;

   sum_type                running_ff, running_in;
   sum_type                best_ff, best_in;
   logic [CNT_BITS-1:0]    next_ff, next_in;    // winning position + 1
   logic [DIST_BITS-1:0]   dist_ff, dist_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;

   logic signed [CMP_BITS-1:0] delta;
   logic signed [CMP_BITS-1:0] dist_abs;
   logic [DIST_BITS-1:0]       pos_gap;
   logic                       in_range;
   diff_type                   addend;
   logic signed [SUM_BITS:0]   sum_wide;
   sum_type                    sum_sat;
   logic                       better;

   always_comb begin
      delta    = $signed(CMP_BITS'(cnt_ff)) - $signed(CMP_BITS'(cur_pos));
      dist_abs = (delta < 0) ? -delta : delta;
      pos_gap  = DIST_BITS'(dist_abs);
      in_range = cnt_ff < CNT_BITS'(MAX_LAYER);
      addend   = (delta == '0) ? '0 : diff;
      sum_wide = (SUM_BITS+1)'(running_ff) + (SUM_BITS+1)'(addend);
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum_sat = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_BITS-1:0];
      end
      better = (sum_sat < best_ff) || ((sum_sat == best_ff) && (pos_gap > dist_ff));

      running_in = running_ff;
      best_in    = best_ff;
      next_in    = next_ff;
      dist_in    = dist_ff;
      cnt_in     = cnt_ff;
      if (ctl.clear) begin
         running_in = '0;
         best_in    = '0;
         next_in    = '0;
         dist_in    = '0;
         cnt_in     = '0;
      end else if (ctl.step && in_range) begin
         running_in = sum_sat;
         cnt_in     = cnt_ff + CNT_BITS'(1);
         if (better) begin
            best_in = sum_sat;
            next_in = cnt_ff + CNT_BITS'(1);
            dist_in = pos_gap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         best_ff    <= '0;
         next_ff    <= '0;
         dist_ff    <= '0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         best_ff    <= best_in;
         next_ff    <= next_in;
         dist_ff    <= dist_in;
         cnt_ff     <= cnt_in;
      end
   end

   assign best_sum   = best_ff;
   assign best_next  = next_ff;
   assign diff_count = cnt_ff;

endmodule

// File: rtl/sift_min_prefix_reposition.sv
// ----------------------------------------------------------------------------
// sift_min_prefix_reposition
// Layer order table with prefix-minimum sift repositioning.
// ----------------------------------------------------------------------------
// Timing: loads and diffs leave the request side ready. A read holds the
// request side in S_RD_OUT, which registers its result. A diff marked last
// starts the move of the sifted node through the order table, which has a
// single read and a single write port: one entry shifts per cycle, so the
// request side stays busy through S_MV_START, S_MV_GRAB, S_MV_SHIFT per entry,
// S_MV_PLACE and S_DONE, or only S_MV_START and S_DONE when the node stays put.
// Both waits stretch while an earlier result is still held on rsp. The request
// side is not ready while a read or a move is in progress. The table needs no
// init pass; entries read before being loaded return arbitrary data.
module sift_min_prefix_reposition #(
   parameter int MAX_LAYER = 64,
   parameter int NODE_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   smp_req_if.sink  req,
   smp_rsp_if.source rsp
);
   import smp_pkg::*;

   localparam int POS_BITS = (MAX_LAYER > 1) ? $clog2(MAX_LAYER) : 1;
   localparam int CNT_BITS = $clog2(MAX_LAYER + 1);
   localparam int CMP_BITS = ((CNT_BITS > CPOS_BITS) ? CNT_BITS : CPOS_BITS) + 1;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_RD_OUT   = 3'd1;
   localparam logic [2:0] S_MV_START = 3'd2;
   localparam logic [2:0] S_MV_GRAB  = 3'd3;
   localparam logic [2:0] S_MV_SHIFT = 3'd4;
   localparam logic [2:0] S_MV_PLACE = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]           state_ff, state_in;
   cpos_type             cp_ff, cp_in;
   logic                 rd_zero_ff, rd_zero_in;
   logic                 dn_ff, dn_in;          // shift direction: toward lower index
   logic [POS_BITS-1:0]  cursor_ff, cursor_in;
   logic [POS_BITS-1:0]  dst_ff, dst_in;
   logic [POS_BITS-1:0]  final_ff, final_in;
   logic [NODE_BITS-1:0] moving_ff, moving_in;
   cpos_type             newpos_ff, newpos_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   node_type             read_node_ff, read_node_in;
   cpos_type             new_pos_ff, new_pos_in;
   sum_type              best_prefix_ff, best_prefix_in;
   logic                 kind_ff, kind_in;

   prefix_ctl_type       ctl;
   sum_type              best_sum;
   logic [CNT_BITS-1:0]  best_next;
   logic [CNT_BITS-1:0]  diff_count;

   logic                 wr_en, rd_en;
   logic [POS_BITS-1:0]  wr_addr, rd_addr;
   logic [NODE_BITS-1:0] wr_data, rd_data;

   logic                 req_fire;
   logic                 slot_free;
   logic                 in_table;
   logic                 move_ok, go_dn, go_up;
   logic [CMP_BITS-1:0]  cp_cmp, cnt_cmp, next_cmp;
   logic [POS_BITS-1:0]  cp_addr, step_addr, next_dst;

   smp_prefix_unit #(
      .MAX_LAYER (MAX_LAYER),
      .CNT_BITS  (CNT_BITS)
   ) u_prefix (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .cur_pos    (req.current_position),
      .diff       (req.crossing_diff),
      .best_sum   (best_sum),
      .best_next  (best_next),
      .diff_count (diff_count)
   );

   smp_order_ram #(
      .DEPTH     (MAX_LAYER),
      .WIDTH     (NODE_BITS),
      .ADDR_BITS (POS_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign in_table  = int'(req.index) < MAX_LAYER;

   always_comb begin
      cp_cmp    = CMP_BITS'(cp_ff);
      cnt_cmp   = CMP_BITS'(diff_count);
      next_cmp  = CMP_BITS'(best_next);
      move_ok   = cp_cmp < cnt_cmp;
      go_dn     = move_ok && (next_cmp < cp_cmp);
      go_up     = move_ok && (next_cmp > cp_cmp + CMP_BITS'(1));
      cp_addr   = POS_BITS'(cp_ff);
      step_addr = dn_ff ? POS_BITS'(1'b1) : POS_BITS'(1'b1);
      next_dst  = dn_ff ? dst_ff - step_addr : dst_ff + step_addr;
   end

   always_comb begin
      state_in       = state_ff;
      cp_in          = cp_ff;
      rd_zero_in     = rd_zero_ff;
      dn_in          = dn_ff;
      cursor_in      = cursor_ff;
      dst_in         = dst_ff;
      final_in       = final_ff;
      moving_in      = moving_ff;
      newpos_in      = newpos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      read_node_in   = read_node_ff;
      new_pos_in     = new_pos_ff;
      best_prefix_in = best_prefix_ff;
      kind_in        = kind_ff;
      ctl            = '0;
      wr_en          = 1'b0;
      wr_addr        = POS_BITS'(req.index);
      wr_data        = NODE_BITS'(req.node_id);
      rd_en          = 1'b0;
      rd_addr        = POS_BITS'(req.index);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req.op)
                  OP_LOAD: begin
                     wr_en = in_table;
                  end
                  OP_DIFF: begin
                     ctl.step = 1'b1;
                     if (req.last) begin
                        cp_in    = req.current_position;
                        state_in = S_MV_START;
                     end
                  end
                  OP_READ: begin
                     rd_en      = in_table;
                     rd_zero_in = !in_table;
                     state_in   = S_RD_OUT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD_OUT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               read_node_in   = rd_zero_ff ? '0 : ID_BITS'(rd_data);
               new_pos_in     = '0;
               best_prefix_in = '0;
               kind_in        = KIND_READ;
               state_in       = S_IDLE;
            end
         end
         S_MV_START: begin
            // fetch the sifted node and set up the shift walk, or finish if it stays put
            rd_addr = cp_addr;
            dst_in  = cp_addr;
            if (go_dn) begin
               rd_en     = 1'b1;
               dn_in     = 1'b1;
               cursor_in = cp_addr - POS_BITS'(1'b1);
               final_in  = POS_BITS'(best_next);
               state_in  = S_MV_GRAB;
            end else if (go_up) begin
               rd_en     = 1'b1;
               dn_in     = 1'b0;
               cursor_in = cp_addr + POS_BITS'(1'b1);
               final_in  = POS_BITS'(best_next - CNT_BITS'(1));
               state_in  = S_MV_GRAB;
            end else begin
               newpos_in = cp_ff;
               state_in  = S_DONE;
            end
         end
         S_MV_GRAB: begin
            moving_in = rd_data;
            rd_en     = 1'b1;
            rd_addr   = cursor_ff;
            cursor_in = dn_ff ? cursor_ff - step_addr : cursor_ff + step_addr;
            state_in  = S_MV_SHIFT;
         end
         S_MV_SHIFT: begin
            // neighbor read last cycle lands in the current slot
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            wr_data = rd_data;
            dst_in  = next_dst;
            rd_addr = cursor_ff;
            if (next_dst == final_ff) begin
               state_in = S_MV_PLACE;
            end else begin
               rd_en     = 1'b1;
               cursor_in = dn_ff ? cursor_ff - step_addr : cursor_ff + step_addr;
            end
         end
         S_MV_PLACE: begin
            wr_en     = 1'b1;
            wr_addr   = final_ff;
            wr_data   = moving_ff;
            newpos_in = CPOS_BITS'(final_ff);
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               read_node_in   = '0;
               new_pos_in     = newpos_ff;
               best_prefix_in = best_sum;
               kind_in        = KIND_SIFT;
               ctl.clear      = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff          <= cp_in;
      rd_zero_ff     <= rd_zero_in;
      dn_ff          <= dn_in;
      cursor_ff      <= cursor_in;
      dst_ff         <= dst_in;
      final_ff       <= final_in;
      moving_ff      <= moving_in;
      newpos_ff      <= newpos_in;
      read_node_ff   <= read_node_in;
      new_pos_ff     <= new_pos_in;
      best_prefix_ff <= best_prefix_in;
      kind_ff        <= kind_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.read_node    = read_node_ff;
   assign rsp.new_position = new_pos_ff;
   assign rsp.best_prefix  = best_prefix_ff;
   assign rsp.kind         = kind_ff;

endmodule
